>>> rtl/thc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thc_pkg
// Types and constants shared by the tournament Hamiltonian cycle unit.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int VW     = 6;   // vertex number width
  localparam int CW     = 7;   // count width, holds 0..64
  localparam int MASK_W = 63;  // beats mask width
  localparam int ROW_W  = 64;  // full row width

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [VW-1:0]     row_vertex;
    logic [MASK_W-1:0] beats_mask;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] cycle_vertex;
    logic          last_vertex;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_B_TOP, S_B_TEST, S_B_EVAL, S_B_LINK,
    S_CI_TEST, S_CI_EVAL, S_SP_I, S_SP_PN, S_SP_J, S_SP_W1, S_SP_W2,
    S_SP_INS, S_EM_LOAD, S_EM_STEP
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_START, OP_B_BEGIN, OP_B_READ, OP_B_ADV, OP_B_INS,
    OP_B_LINK, OP_CI_BEGIN, OP_CI_READ, OP_CI_ADV, OP_CI_DONE, OP_SP_RDPE,
    OP_SP_PN, OP_SP_RDJ, OP_SP_W1, OP_SP_INS1, OP_SP_INS2, OP_SP_NEXTJ,
    OP_SP_NEXTI, OP_EM_BEGIN, OP_EM_LOAD, OP_EM_STEP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;     // no vertices in use
    logic v_end;      // all vertices placed in path
    logic cnt_end;    // walk counter reached path length
    logic jc_end;     // walk counter reached cycle length
    logic i_end;      // prefix index reached path length
    logic win;        // last edge lookup result
    logic fit;        // both splice checks passed
    logic have_prev;  // build walk has a predecessor
    logic out_free;   // output register can take a word
  } status_t;

endpackage
`default_nettype wire

>>> rtl/thc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thc_ctrl
// Sequencer: takes load words and steps path build, cycle seed, splicing and emission.
// ----------------------------------------------------------------------------
module thc_ctrl import thc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_action,
  output logic         in_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_RUN) begin
            cmd.op     = OP_START;
            state_next = S_START;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_START: state_next = sts.n_zero ? S_IDLE : S_B_TOP;
      S_B_TOP: begin
        if (sts.v_end) begin
          cmd.op     = OP_CI_BEGIN;
          state_next = S_CI_TEST;
        end else begin
          cmd.op     = OP_B_BEGIN;
          state_next = S_B_TEST;
        end
      end
      S_B_TEST: begin
        if (sts.cnt_end) begin
          cmd.op     = OP_B_LINK;   // append at tail
          state_next = S_B_TOP;
        end else begin
          cmd.op     = OP_B_READ;
          state_next = S_B_EVAL;
        end
      end
      S_B_EVAL: begin
        if (sts.win) begin
          cmd.op     = OP_B_ADV;
          state_next = S_B_TEST;
        end else begin
          cmd.op     = OP_B_INS;
          state_next = sts.have_prev ? S_B_LINK : S_B_TOP;
        end
      end
      S_B_LINK: begin
        cmd.op     = OP_B_LINK;
        state_next = S_B_TOP;
      end
      S_CI_TEST: begin
        if (sts.cnt_end) begin
          cmd.op     = OP_CI_DONE;
          state_next = S_SP_I;
        end else begin
          cmd.op     = OP_CI_READ;
          state_next = S_CI_EVAL;
        end
      end
      S_CI_EVAL: begin
        cmd.op     = OP_CI_ADV;
        state_next = S_CI_TEST;
      end
      S_SP_I: begin
        if (sts.i_end) begin
          cmd.op     = OP_EM_BEGIN;
          state_next = S_EM_LOAD;
        end else begin
          cmd.op     = OP_SP_RDPE;
          state_next = S_SP_PN;
        end
      end
      S_SP_PN: begin
        cmd.op     = OP_SP_PN;
        state_next = S_SP_J;
      end
      S_SP_J: begin
        if (sts.jc_end) begin
          cmd.op     = OP_SP_NEXTI;
          state_next = S_SP_I;
        end else begin
          cmd.op     = OP_SP_RDJ;
          state_next = S_SP_W1;
        end
      end
      S_SP_W1: begin
        cmd.op     = OP_SP_W1;
        state_next = S_SP_W2;
      end
      S_SP_W2: begin
        if (sts.fit) begin
          cmd.op     = OP_SP_INS1;
          state_next = S_SP_INS;
        end else begin
          cmd.op     = OP_SP_NEXTJ;
          state_next = S_SP_J;
        end
      end
      S_SP_INS: begin
        cmd.op     = OP_SP_INS2;
        state_next = S_SP_I;
      end
      S_EM_LOAD: begin
        if (sts.jc_end) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.op     = OP_EM_LOAD;
          state_next = S_EM_STEP;
        end
      end
      S_EM_STEP: begin
        cmd.op     = OP_EM_STEP;
        state_next = S_EM_LOAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/thc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thc_dp
// Datapath: adjacency memory, next-pointer list memory, walk registers,
// edge lookup and output register.
// ----------------------------------------------------------------------------
module thc_dp import thc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          cmd,
  input  wire in_word_t      in_data,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic          out_stall,
  output status_t            sts,
  output logic               out_valid,
  output out_word_t          out_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [CW-1:0] NMAX = CW'(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] mat [MAX_VERTICES];
  logic [VW-1:0]           nxt [MAX_VERTICES];

  logic [CW-1:0] vc, n, v, cnt, plen, clen, i, start_i;
  logic [VW-1:0] ph, cur, prev, start_v, start_next, ch, ct, pe, pnext, cj, cjn, pred;
  logic          have_prev, w1;

  // edge lookup
  logic [VW-1:0]           wa, wb, row_addr, bit_sel;
  logic                    a_gt;
  logic [MAX_VERTICES-1:0] row_q;
  logic [VW-1:0]           bit_q;
  logic                    inv_q, eq_q, win;

  // list memory ports
  logic          nx_we;
  logic [VW-1:0] nx_wa, nx_wd, nx_ra, nx_rd;

  logic [ROW_W-1:0] row_w;
  logic             load_ok;

  always_comb begin
    wa    = cur;
    wb    = v[VW-1:0];
    nx_ra = cur;
    case (cmd.op)
      OP_CI_READ: wb = ph;
      OP_SP_RDJ: begin
        wa    = pe;
        wb    = cj;
        nx_ra = cj;
      end
      OP_SP_W1: begin
        wa = pred;
        wb = ph;
      end
      OP_SP_RDPE: nx_ra = pe;
      default: ;
    endcase
  end

  assign a_gt     = wa > wb;
  assign row_addr = a_gt ? wa : wb;
  assign bit_sel  = a_gt ? wb : wa;
  assign win      = !eq_q && (row_q[bit_q[AW-1:0]] ^ inv_q);

  always_comb begin
    nx_we = 1'b1;
    nx_wa = prev;
    nx_wd = v[VW-1:0];
    case (cmd.op)
      OP_B_INS: begin
        nx_wa = v[VW-1:0];
        nx_wd = cur;
      end
      OP_B_LINK: ;
      OP_CI_DONE: begin
        nx_wa = start_v;   // close the seed cycle
        nx_wd = ph;
      end
      OP_SP_INS1: begin
        nx_wa = pred;
        nx_wd = ph;
      end
      OP_SP_INS2: begin
        nx_wa = pe;
        nx_wd = cj;
      end
      default: nx_we = 1'b0;
    endcase
  end

  assign row_w = ROW_W'({1'b0, in_data.beats_mask})
               & ((ROW_W'(1) << in_data.row_vertex) - ROW_W'(1));
  assign load_ok = (in_data.row_vertex != '0) && ({1'b0, in_data.row_vertex} < NMAX);

  always_ff @(posedge clk) begin
    row_q <= mat[row_addr[AW-1:0]];
    bit_q <= bit_sel;
    inv_q <= !a_gt;
    eq_q  <= (wa == wb);
    nx_rd <= nxt[nx_ra[AW-1:0]];
    if (cmd.op == OP_LOAD && load_ok) begin
      mat[in_data.row_vertex[AW-1:0]] <= row_w[MAX_VERTICES-1:0];
    end
    if (nx_we) begin
      nxt[nx_wa[AW-1:0]] <= nx_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= NMAX;
    end else if (cfg_we) begin
      vc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EM_LOAD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        n    <= (vc > NMAX) ? NMAX : vc;
        ph   <= '0;
        plen <= CW'(1);
        v    <= CW'(1);
      end
      OP_B_BEGIN: begin
        cur       <= ph;
        have_prev <= 1'b0;
        cnt       <= '0;
      end
      OP_B_ADV: begin
        prev      <= cur;
        have_prev <= 1'b1;
        cur       <= nx_rd;
        cnt       <= cnt + CW'(1);
      end
      OP_B_INS: begin
        if (!have_prev) begin
          ph   <= v[VW-1:0];
          plen <= plen + CW'(1);
          v    <= v + CW'(1);
        end
      end
      OP_B_LINK: begin
        plen <= plen + CW'(1);
        v    <= v + CW'(1);
      end
      OP_CI_BEGIN: begin
        cur     <= ph;
        cnt     <= '0;
        start_v <= ph;
        start_i <= '0;
      end
      OP_CI_ADV: begin
        // the head, then the last vertex at index two or more that beats it
        if (cnt == '0 || (cnt >= CW'(2) && win)) begin
          start_v    <= cur;
          start_i    <= cnt;
          start_next <= nx_rd;
        end
        cur <= nx_rd;
        cnt <= cnt + CW'(1);
      end
      OP_CI_DONE: begin
        ch   <= ph;
        ct   <= start_v;
        clen <= start_i + CW'(1);
        ph   <= start_next;
        pe   <= start_next;
        plen <= plen - start_i - CW'(1);
        i    <= '0;
      end
      OP_SP_PN: begin
        pnext <= nx_rd;
        cnt   <= '0;
        cj    <= ch;
        pred  <= ct;
      end
      OP_SP_W1: begin
        w1  <= win;
        cjn <= nx_rd;
      end
      OP_SP_NEXTJ: begin
        pred <= cj;
        cj   <= cjn;
        cnt  <= cnt + CW'(1);
      end
      OP_SP_NEXTI: begin
        i  <= i + CW'(1);
        pe <= pnext;
      end
      OP_SP_INS2: begin
        if (cnt == '0) begin
          ch <= ph;
        end
        clen <= clen + i + CW'(1);
        plen <= plen - i - CW'(1);
        ph   <= pnext;
        pe   <= pnext;
        i    <= '0;
      end
      OP_EM_BEGIN: begin
        cur <= ch;
        cnt <= '0;
      end
      OP_EM_LOAD: begin
        out_data.cycle_vertex <= cur;
        out_data.last_vertex  <= (cnt + CW'(1) == clen);
      end
      OP_EM_STEP: begin
        cur <= nx_rd;
        cnt <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.n_zero    = (n == '0);
    sts.v_end     = (v == n);
    sts.cnt_end   = (cnt == plen);
    sts.jc_end    = (cnt == clen);
    sts.i_end     = (i == plen);
    sts.win       = win;
    sts.fit       = w1 && win;
    sts.have_prev = have_prev;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

>>> rtl/tournament_hamiltonian_cycle_unit.sv
`default_nettype none
// Operation: a load word writes one row while idle; a run word builds the
//   path by insertion compares, seeds a cycle, splices path prefixes into it
//   by splice checks, then emits the cycle one vertex per output word.
// Flow: one run word at a time; in_stall stays high until the run finishes,
//   and load words are taken only while the sequencer is idle.
// Reset: sequencer idle, output empty, vertex_count = MAX_VERTICES; rows and
//   lists are undefined until written.
// ----------------------------------------------------------------------------
// tournament_hamiltonian_cycle_unit
// Hamiltonian cycle search in a tournament held as lower-triangle rows.
// ----------------------------------------------------------------------------
module tournament_hamiltonian_cycle_unit import thc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_word_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_word_t          out_data,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_data
);

  // Path and cycle are singly linked lists sharing one next-pointer memory,
  // since every vertex sits in exactly one of them. The cycle list is kept
  // circular so the predecessor of its head is the fixed tail.
  cmd_t    cmd;
  status_t sts;

  thc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  thc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a new word enters the output register only from the emit step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_EM_LOAD))
    else $error("output word without emit step");

  // emit never overwrites a word still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EM_LOAD |-> (!out_valid || !out_stall))
    else $error("output word overwritten");

  // a run word makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.action == ACT_RUN) |=> in_stall)
    else $error("run word accepted without going busy");

endmodule
`default_nettype wire
